/* hw/rtl/rsfc_pkg.sv */
// rsfc_pkg: shared constants for the ray / sphere far-exit pipeline
// no dependencies; imported by ray_sphere_far_clip
package rsfc_pkg;

    // default field widths, Q.4 positions and Q1.(DIR_WIDTH-2) directions
    localparam int COORD_WIDTH_DEF = 24;
    localparam int DIR_WIDTH_DEF   = 16;

endpackage

/* hw/rtl/ray_sphere_far_clip.sv */
// ray_sphere_far_clip: far exit point of a ray leaving a sphere, fully pipelined
// depends on rsfc_pkg for default widths
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata: origin xyz, dir xyz, center xyz, radius
//  m_*     | out | m_tvalid/m_tready | m_tdata: exit xyz; m_tuser: hit
//
// one item per cycle sustained while the output is not stalled; the pipeline depth is
// set by the restoring square root, one root bit per pipeline stage
// rst_n clears valid bits only; data registers are not reset
// all stages advance together while the output skid register is empty; a stalled
// output fills the skid register, which holds the pipeline until it drains

module ray_sphere_far_clip #(
    parameter int COORD_WIDTH = rsfc_pkg::COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = rsfc_pkg::DIR_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, sphere_radius, zero pad
    input  logic [((7*COORD_WIDTH+3*DIR_WIDTH+6)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // exit_x, exit_y, exit_z, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // hit
    output logic [0:0] m_tuser
);
    import rsfc_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = DIR_WIDTH;
    localparam int DF   = DW - 2;
    localparam int RDW  = CW - 1;
    localparam int DLW  = CW + 1;           // center - origin
    localparam int PW   = DLW + DW;         // delta * dir
    localparam int DOTW = PW + 2;           // sum of three products
    localparam int TW   = CW + 4;           // t, known non-negative
    localparam int RW   = 2*CW + 9;         // radicand
    localparam int SQW  = (RW + 1) / 2;     // root bits
    localparam int LW   = SQW + 1;          // t + root
    localparam int MW   = LW + 1 + DW;      // len * dir
    localparam int EW   = MW - DF + 1;      // origin + step
    localparam int OUTW = ((3*CW + 7) / 8) * 8;

    localparam int OFS_DIR = 3*CW;
    localparam int OFS_CEN = 3*CW + 3*DW;
    localparam int OFS_RAD = 6*CW + 3*DW;

    localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    typedef struct packed {
        logic [2:0][CW-1:0] org;
        logic [2:0][DW-1:0] dir;
        logic [TW-1:0]      t;
        logic               hit;
    } side_t;

    logic adv;

    // ---------------------------------------------------------------- stage 1
    logic               v1_reg;
    logic [2:0][DLW-1:0] d1_reg;
    logic [2:0][DW-1:0]  dir1_reg;
    logic [2:0][CW-1:0]  org1_reg;
    logic [RDW-1:0]      rad1_reg;

    // ---------------------------------------------------------------- stage 2
    logic               v2_reg;
    logic [2:0][PW-1:0]    pd2_reg;
    logic [2:0][2*DLW-1:0] sq2_reg;
    logic [2*RDW-1:0]      rr2_reg;
    logic [2:0][DW-1:0]    dir2_reg;
    logic [2:0][CW-1:0]    org2_reg;

    // ---------------------------------------------------------------- stage 3
    logic               v3_reg;
    logic [TW-1:0]      t3_reg;
    logic               tneg3_reg;
    logic [RW-1:0]      dsq3_reg;
    logic [2*RDW-1:0]   rr3_reg;
    logic [2:0][DW-1:0] dir3_reg;
    logic [2:0][CW-1:0] org3_reg;
    logic signed [DOTW-1:0] dot3_next;
    logic signed [DOTW-1:0] sh3_next;
    logic [RW-1:0]      dsq3_next;

    // ---------------------------------------------------------------- stage 4
    logic               v4_reg;
    logic [2*TW-1:0]    tt4_reg;
    logic [TW-1:0]      t4_reg;
    logic               tneg4_reg;
    logic [RW-1:0]      dsq4_reg;
    logic [2*RDW-1:0]   rr4_reg;
    logic [2:0][DW-1:0] dir4_reg;
    logic [2:0][CW-1:0] org4_reg;

    // ------------------------------------------- stage 5 and root stages
    logic              sv_reg   [0:SQW];
    logic [RW-1:0]     rem_reg  [0:SQW];
    logic [SQW-1:0]    q_reg    [0:SQW];
    side_t             side_reg [0:SQW];
    logic [RW-1:0]     rhs5_next;
    logic              hit5_next;

    // ---------------------------------------------------------- length, scale
    logic               vl_reg;
    logic [LW-1:0]      len_reg;
    side_t              sidel_reg;
    logic               vm_reg;
    logic [2:0][MW-1:0] prod_reg;
    logic [2:0][CW-1:0] orgm_reg;
    logic               hitm_reg;

    // ---------------------------------------------------------- output side
    logic               out_v_reg;
    logic               out_hit_reg;
    logic [2:0][CW-1:0] out_ex_reg;
    logic               skid_v_reg;
    logic               skid_hit_reg;
    logic [2:0][CW-1:0] skid_ex_reg;
    logic [2:0][CW-1:0] res_ex;

    assign adv      = !skid_v_reg;
    assign s_tready = adv;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
            vl_reg    <= 1'b0;
            vm_reg    <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            sv_reg[0] <= v4_reg;
            vl_reg    <= sv_reg[SQW];
            vm_reg    <= vl_reg;
        end
    end

    always_comb
    begin
        dot3_next = '0;
        dsq3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dot3_next = dot3_next + DOTW'($signed(pd2_reg[i]));
            dsq3_next = dsq3_next + RW'(sq2_reg[i]);
        end
        sh3_next  = dot3_next >>> DF;
        rhs5_next = RW'(rr4_reg) + RW'(tt4_reg);
        hit5_next = !tneg4_reg && (dsq4_reg <= rhs5_next);
    end

    // front stages: delta, products, sums, t squared, radicand
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]   <= DLW'($signed(s_tdata[OFS_CEN + i*CW +: CW]))
                             - DLW'($signed(s_tdata[i*CW +: CW]));
                dir1_reg[i] <= s_tdata[OFS_DIR + i*DW +: DW];
                org1_reg[i] <= s_tdata[i*CW +: CW];

                pd2_reg[i]  <= $signed(d1_reg[i]) * $signed(dir1_reg[i]);
                sq2_reg[i]  <= $signed(d1_reg[i]) * $signed(d1_reg[i]);
            end
            rad1_reg <= s_tdata[OFS_RAD +: RDW];

            rr2_reg  <= rad1_reg * rad1_reg;
            dir2_reg <= dir1_reg;
            org2_reg <= org1_reg;

            t3_reg    <= sh3_next[TW-1:0];
            tneg3_reg <= dot3_next[DOTW-1];
            dsq3_reg  <= dsq3_next;
            rr3_reg   <= rr2_reg;
            dir3_reg  <= dir2_reg;
            org3_reg  <= org2_reg;

            tt4_reg   <= t3_reg * t3_reg;
            t4_reg    <= t3_reg;
            tneg4_reg <= tneg3_reg;
            dsq4_reg  <= dsq3_reg;
            rr4_reg   <= rr3_reg;
            dir4_reg  <= dir3_reg;
            org4_reg  <= org3_reg;

            // misses run through the root with a zero radicand
            rem_reg[0]      <= hit5_next ? (rhs5_next - dsq4_reg) : '0;
            q_reg[0]        <= '0;
            side_reg[0].org <= org4_reg;
            side_reg[0].dir <= dir4_reg;
            side_reg[0].t   <= t4_reg;
            side_reg[0].hit <= hit5_next;
        end
    end

    // restoring square root, one result bit per stage, msb first
    for (genvar g = 0; g < SQW; g++)
    begin : g_root
        localparam int K = SQW - 1 - g;
        logic [RW+1:0] trial;
        logic          take;

        always_comb
        begin
            // (q + 2^K)^2 - q^2, with q holding only bits above K
            trial = (RW+2)'({{(RW+2-SQW){1'b0}}, q_reg[g]} << (K + 1))
                  | ((RW+2)'(1) << (2*K));
            take  = {2'b00, rem_reg[g]} >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[g+1] <= 1'b0;
            else if (adv)
                sv_reg[g+1] <= sv_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g+1]  <= take ? (rem_reg[g] - trial[RW-1:0]) : rem_reg[g];
                q_reg[g+1]    <= take ? (q_reg[g] | (SQW'(1) << K)) : q_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    // path length and per-axis step
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg   <= LW'(side_reg[SQW].t) + LW'(q_reg[SQW]);
            sidel_reg <= side_reg[SQW];
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= $signed({1'b0, len_reg}) * $signed(sidel_reg.dir[i]);
            orgm_reg <= sidel_reg.org;
            hitm_reg <= sidel_reg.hit;
        end
    end

    // origin plus floored step, saturated, zero on a miss
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [EW-1:0] sum;
            sum = EW'($signed(orgm_reg[i])) + EW'($signed(prod_reg[i][MW-1:DF]));
            if (!hitm_reg)
                res_ex[i] = '0;
            else if (sum > SAT_HI)
                res_ex[i] = SAT_HI[CW-1:0];
            else if (sum < SAT_LO)
                res_ex[i] = SAT_LO[CW-1:0];
            else
                res_ex[i] = sum[CW-1:0];
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
                skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || m_tready)
            out_v_reg <= vm_reg;
        else if (vm_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_tready)
            begin
                out_hit_reg <= skid_hit_reg;
                out_ex_reg  <= skid_ex_reg;
            end
        end
        else if (!out_v_reg || m_tready)
        begin
            out_hit_reg <= hitm_reg;
            out_ex_reg  <= res_ex;
        end
        else
        begin
            skid_hit_reg <= hitm_reg;
            skid_ex_reg  <= res_ex;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tuser[0] = out_hit_reg;
    assign m_tdata    = OUTW'({out_ex_reg[2], out_ex_reg[1], out_ex_reg[0]});

    // skid stage only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid item without output item");

    // a miss leaves every exit coordinate at zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("miss with nonzero exit point");

    // a blocked skid item is kept until the sink takes the output item
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !m_tready) |=> (skid_v_reg && $stable(skid_ex_reg)))
        else $error("skid item lost while stalled");

    // the skid stage does not fill while the sink is ready
    a_adv_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!skid_v_reg && m_tready) |=> !skid_v_reg)
        else $error("skid filled while sink was ready");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for ray_sphere_far_clip, far exit point of a ray through a sphere
// depends on rsfc_pkg and ray_sphere_far_clip; exact integer prediction, random stream stalls
module tb;

    localparam int CW          = rsfc_pkg::COORD_WIDTH_DEF;
    localparam int DW          = rsfc_pkg::DIR_WIDTH_DEF;
    localparam int FRAC        = DW - 2;
    localparam int SW          = ((7*CW + 3*DW + 6) / 8) * 8;
    localparam int MW          = ((3*CW + 7) / 8) * 8;
    localparam int LATENCY     = CW + 13;
    localparam int STALL_LIMIT = 4000;
    localparam longint POS_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint POS_MIN = -POS_MAX - 1;

    typedef struct {
        logic signed [CW-1:0] org [3];
        logic signed [DW-1:0] dir [3];
        logic signed [CW-1:0] ctr [3];
        logic        [CW-2:0] radius;
    } ray_t;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] pos [3];
    } exit_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // center_x, center_y, center_z, sphere_radius, zero pad
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // exit_x, exit_y, exit_z, zero pad
    logic [MW-1:0] m_tdata;
    // hit
    logic [0:0]    m_tuser;

    exit_t exit_q [$];
    exit_t want;
    logic signed [CW-1:0] got;
    bit    idle_en = 1'b1;
    int    fault_cnt = 0;
    int    rays_sent = 0;
    int    exits_seen = 0;
    int    hits_seen = 0;
    int    sat_seen = 0;
    int    quiet_cycles = 0;

    ray_sphere_far_clip #(
        .COORD_WIDTH(CW),
        .DIR_WIDTH  (DW)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int cx, int cy, int cz, int rad);
        ray_t r;
        r.org[0] = CW'(ox);
        r.org[1] = CW'(oy);
        r.org[2] = CW'(oz);
        r.dir[0] = DW'(dx);
        r.dir[1] = DW'(dy);
        r.dir[2] = DW'(dz);
        r.ctr[0] = CW'(cx);
        r.ctr[1] = CW'(cy);
        r.ctr[2] = CW'(cz);
        r.radius = (CW-1)'(rad);
        return r;
    endfunction

    function automatic logic [SW-1:0] pack_ray(ray_t r);
        logic [SW-1:0] v;
        v = '0;
        for (int i = 0; i < 3; i++)
        begin
            v[i*CW +: CW]                = r.org[i];
            v[3*CW + i*DW +: DW]         = r.dir[i];
            v[3*CW + 3*DW + i*CW +: CW]  = r.ctr[i];
        end
        v[6*CW + 3*DW +: CW-1] = r.radius;
        return v;
    endfunction

    // exact fixed-point far exit: t by projection, chord half length by integer root
    function automatic exit_t far_exit(ray_t r);
        exit_t  e;
        longint dl [3];
        longint dot, t, dsq, rr, rem, root, cand, len, p, rad;
        dot = 0;
        dsq = 0;
        e.hit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            e.pos[i] = '0;
            dl[i] = longint'(r.ctr[i]) - longint'(r.org[i]);
            dot += dl[i] * longint'(r.dir[i]);
            dsq += dl[i] * dl[i];
        end
        t = dot >>> FRAC;
        if (t < 0)
            return e;
        rad = longint'(r.radius);
        rr = rad * rad + t * t;
        if (dsq > rr)
            return e;
        rem = rr - dsq;
        root = 0;
        for (int b = 29; b >= 0; b--)
        begin
            cand = root | (64'sd1 <<< b);
            if (cand * cand <= rem)
                root = cand;
        end
        len = t + root;
        e.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            p = longint'(r.org[i]) + ((len * longint'(r.dir[i])) >>> FRAC);
            if (p > POS_MAX)
                p = POS_MAX;
            else if (p < POS_MIN)
                p = POS_MIN;
            e.pos[i] = p[CW-1:0];
        end
        return e;
    endfunction

    // ray aimed roughly at a random sphere, from outside or from inside it
    function automatic ray_t aimed_ray(bit from_inside);
        ray_t   r;
        int     span, o_lim, o;
        longint dl [3];
        real    aim [3];
        real    mag, span_len, fac, rad;
        span = ($urandom_range(99) < 85) ? $urandom_range(14, 4) : $urandom_range(21, 15);
        o_lim = (1 << (CW - 1)) - (1 << 21) - 1;
        span_len = 0.0;
        for (int i = 0; i < 3; i++)
        begin
            o = int'($urandom_range(2 * o_lim)) - o_lim;
            dl[i] = longint'($urandom_range(2 ** (span + 1))) - (64'sd1 <<< span);
            r.org[i] = CW'(o);
            r.ctr[i] = CW'(longint'(o) + dl[i]);
            span_len += real'(dl[i]) * real'(dl[i]);
        end
        span_len = $sqrt(span_len);
        mag = 0.0;
        for (int i = 0; i < 3; i++)
        begin
            aim[i] = real'(dl[i]) +
                     (real'($urandom_range(2000)) - 1000.0) / 4000.0 * span_len;
            mag += aim[i] * aim[i];
        end
        mag = $sqrt(mag);
        if (mag < 1.0)
        begin
            aim[0] = 1.0;
            aim[1] = 0.0;
            aim[2] = 0.0;
            mag = 1.0;
        end
        for (int i = 0; i < 3; i++)
            r.dir[i] = DW'($rtoi(aim[i] / mag * real'(1 << FRAC)));
        if (from_inside)
            fac = 1.05 + real'($urandom_range(200)) / 100.0;
        else
            fac = real'($urandom_range(100, 5)) / 100.0;
        rad = span_len * fac + (from_inside ? 16.0 : 0.0);
        if (rad > real'(POS_MAX))
            rad = real'(POS_MAX);
        r.radius = (CW-1)'($rtoi(rad));
        return r;
    endfunction

    // axis ray with a tiny sphere near the axis: exact grazing and zero radius cases
    function automatic ray_t axis_ray();
        ray_t r;
        int   ax, sgn, o, k;
        ax = $urandom_range(2);
        sgn = $urandom_range(1) ? 1 : -1;
        k = $urandom_range(1 << 20);
        for (int i = 0; i < 3; i++)
        begin
            o = int'($urandom_range(1 << 23)) - (1 << 22);
            r.org[i] = CW'(o);
            r.dir[i] = (i == ax) ? DW'(sgn << FRAC) : '0;
            if (i == ax)
                r.ctr[i] = CW'(o + sgn * k);
            else
                r.ctr[i] = CW'(o + int'($urandom_range(2)) - 1);
        end
        r.radius = (CW-1)'($urandom_range(3));
        return r;
    endfunction

    function automatic ray_t raw_ray();
        ray_t r;
        for (int i = 0; i < 3; i++)
        begin
            r.org[i] = CW'($urandom);
            r.dir[i] = DW'($urandom);
            r.ctr[i] = CW'($urandom);
        end
        r.radius = (CW-1)'($urandom);
        return r;
    endfunction

    // valid stays high across back-to-back items, it only drops in an idle gap
    task automatic send_ray(input ray_t r);
        while (idle_en && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_ray(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exit_q.push_back(far_exit(r));
        rays_sent++;
    endtask

    task automatic test_basic_geometry();
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 160, 0, 0, 32));
        send_ray(mk_ray(0, 0, 0, -16384, 0, 0, 160, 0, 0, 32));
        send_ray(mk_ray(100, -50, 7, 0, 16384, 0, 120, -40, 0, 400));
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 160, 0, 80, 32));
        send_ray(mk_ray(-5, 3, 0, 16384, 0, 0, 315, 3, 0, 0));
        send_ray(mk_ray(-5, 3, 0, 16384, 0, 0, 315, 4, 0, 0));
        send_ray(mk_ray(0, 0, 0, 16384, 0, 0, 160, 32, 0, 32));
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(10, 20, 30, 0, 0, 0, 50, 20, 30, 64));
    endtask

    task automatic test_direction_codes();
        send_ray(mk_ray(0, 0, 0, -32768, -32768, -32768, -1600, -1600, -1600, 100));
        send_ray(mk_ray(0, 0, 0, 32767, 32767, 32767, 1600, 1600, 1600, 3000));
        send_ray(mk_ray(-8388608, -8388608, -8388608, -32768, -32768, -32768,
                        -8388608, -8388608, -8388608, 0));
        send_ray(mk_ray(-8388608, -8388608, -8388608, 32767, 32767, 32767,
                        8388607, 8388607, 8388607, 8388607));
        send_ray(mk_ray(4000, -4000, 0, 11585, -11585, 0, 8000, -8000, 0, 200));
    endtask

    task automatic test_saturation();
        send_ray(mk_ray(8388000, 8388000, 8388000, 9459, 9459, 9459,
                        8388100, 8388100, 8388100, 8388607));
        send_ray(mk_ray(-8388000, -8388000, -8388000, -9459, -9459, -9459,
                        -8388100, -8388100, -8388100, 8388607));
        send_ray(mk_ray(8388607, 8388607, 8388607, 32767, 32767, 32767,
                        8388607, 8388607, 8388607, 8388607));
        send_ray(mk_ray(-8388608, 0, 8388607, 16384, 0, -16384,
                        8388607, 0, -8388608, 8388607));
        send_ray(mk_ray(8388000, 0, 0, 16384, 0, 0, 8388300, 0, 0, 500));
    endtask

    task automatic test_random_rays(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_ray(aimed_ray(1'b0));
            else if (pick < 65)
                send_ray(aimed_ray(1'b1));
            else if (pick < 78)
                send_ray(axis_ray());
            else
                send_ray(raw_ray());
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !(idle_en && $urandom_range(99) < 12);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (exit_q.size() == 0)
            begin
                fault_cnt++;
                $display("%0t: exit item with none expected: hit %0b data %h",
                         $time, m_tuser[0], m_tdata);
            end
            else
            begin
                want = exit_q.pop_front();
                exits_seen++;
                if (want.hit)
                    hits_seen++;
                if (m_tuser[0] !== want.hit)
                begin
                    fault_cnt++;
                    $display("%0t: hit expected %0b got %0b", $time, want.hit, m_tuser[0]);
                end
                for (int i = 0; i < 3; i++)
                begin
                    got = m_tdata[i*CW +: CW];
                    if (want.hit && (want.pos[i] == POS_MAX[CW-1:0] ||
                                     want.pos[i] == POS_MIN[CW-1:0]))
                        sat_seen++;
                    if (got !== want.pos[i])
                    begin
                        fault_cnt++;
                        $display("%0t: exit axis %0d expected %0d got %0d",
                                 $time, i, want.pos[i], got);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_geometry();
        test_direction_codes();
        test_saturation();
        test_random_rays(400);
        // long stretch at full rate on both sides
        idle_en <= 1'b0;
        test_random_rays(350);
        idle_en <= 1'b1;
        test_random_rays(380);
        s_tvalid <= 1'b0;
        while (exit_q.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        $display("rays sent %0d, exits checked %0d, hits %0d, saturated coordinates %0d",
                 rays_sent, exits_seen, hits_seen, sat_seen);
        $display("mismatches %0d", fault_cnt);
        if (fault_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rsfc_pkg.sv
hw/rtl/ray_sphere_far_clip.sv
verif/tb.sv
